[rtl/dfc_pkg.sv]
// ----------------------------------------------------------------------------
// dfc_pkg: shared types and constants for the descriptor framer
// Sequencer step codes, descriptor section codes and stream constants.
// ----------------------------------------------------------------------------
package dfc_pkg;

   // stream constants
   localparam int unsigned FrameLen       = 17;
   localparam int unsigned SegmentFields  = 8;
   localparam logic [15:0] CrcPoly        = 16'h8408;
   localparam logic [15:0] CrcInit        = 16'hFFFF;
   localparam logic [4:0]  FrameLastPos   = 5'(FrameLen - 1);

   // register indexes of the configuration port
   localparam logic [1:0] CsrDilCount  = 2'd0;
   localparam logic [1:0] CsrFirstLen  = 2'd1;
   localparam logic [1:0] CsrSecondLen = 2'd2;

   // input item codes
   localparam logic ModeStart = 1'b0;

   // descriptor section the next field item belongs to
   typedef enum logic [2:0] {
      SEC_IDLE  = 3'd0,
      SEC_SEQ1  = 3'd1,
      SEC_SEQ2  = 3'd2,
      SEC_SIZES = 3'd3,
      SEC_CODES = 3'd4,
      SEC_DIL   = 3'd5
   } sect_type;

   // position sequencer steps
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ONES,
      ST_HDR_DIL,
      ST_HDR_CLOSE1,
      ST_HDR_LEN1,
      ST_HDR_LEN2,
      ST_HDR_CLOSE2,
      ST_FIELD,
      ST_FIELD_CLOSE,
      ST_FIN_CLOSE,
      ST_CRC,
      ST_TAIL
   } step_type;

endpackage

[rtl/dil_descriptor_framer_crc_core.sv]
// ----------------------------------------------------------------------------
// dil_descriptor_framer_crc_core: DIL descriptor framer with CRC-16
// Serialises a DIL descriptor into 17-position frames, one position a cycle.
// ----------------------------------------------------------------------------
// Usage
//   req_* channel (valid/ready): one transaction per descriptor item. mode 0
//   starts a descriptor and yields the 52-position header; mode 1 carries the
//   next field byte. A mode 1 transaction while no descriptor is open yields
//   nothing. csr_* is a plain write port for dil_count and the two sequence
//   lengths; the user must write it only while the block is idle (unenforced).
//   rsp_* channel (valid/ready): one transaction per stream position, with
//   rsp_last high on the final position of the CRC frame tail.
//   Timing: positions come out of a bit-serial sequencer, one per cycle, with
//   a field byte held in an 8-bit shift register and the CRC in a 16-bit
//   LFSR. A transaction is taken only while the sequencer is idle; the step
//   it sets is registered first and its positions then pass through the
//   output register. When the final item finds its frame already closed,
//   the sequencer passes its closing step without emitting a position.
//   Reset: synchronous, clears control and config registers; CRC preset to ones.
//   Stall: while rsp_valid is high and rsp_ready is low, the output register
//   holds and the sequencer waits; no position is lost or repeated.
// ----------------------------------------------------------------------------
module dil_descriptor_framer_crc_core
   import dfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_field_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_symbol,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   // configuration registers
   logic [7:0] dil_count_ff, first_len_ff, second_len_ff;

   // descriptor state
   step_type    step_ff, step_in;
   sect_type    section_ff, section_in;
   logic [7:0]  field_cnt_ff, field_cnt_in;
   logic [4:0]  frame_pos_ff, frame_pos_in;
   logic        parity_ff, parity_in;
   logic [15:0] crc_ff, crc_in;

   // sequencer working registers
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  shift_ff, shift_in;
   logic        whole_ff, whole_in;
   logic        close_ff, close_in;
   logic        fin_ff, fin_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_symbol_ff, rsp_symbol_in;
   logic        rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic        emit_req, emit, feed, sym_last, slot_free, accept;
   logic [7:0]  sym;
   logic [8:0]  cnt_next, dil_total;
   logic        crc_fb;
   sect_type    after_first;
   logic [7:0]  first_hdr, second_hdr;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (step_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign cnt_next    = {1'b0, field_cnt_ff} + 9'd1;
   assign dil_total   = ({1'b0, dil_count_ff} + 9'd1) & 9'h1FE;
   assign after_first = (second_len_ff != 8'd0) ? SEC_SEQ2 : SEC_SIZES;
   assign first_hdr   = {1'b0, 7'(first_len_ff - 8'd1)};
   assign second_hdr  = {1'b0, 7'(second_len_ff - 8'd1)};
   assign emit        = emit_req && slot_free;
   assign crc_fb      = sym[0] ^ crc_ff[0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dil_count_ff  <= 8'd0;
         first_len_ff  <= 8'd0;
         second_len_ff <= 8'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrDilCount:  dil_count_ff  <= csr_write_data;
            CsrFirstLen:  first_len_ff  <= csr_write_data;
            CsrSecondLen: second_len_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         section_ff   <= SEC_IDLE;
         field_cnt_ff <= 8'd0;
         frame_pos_ff <= 5'd0;
         parity_ff    <= 1'b0;
         crc_ff       <= CrcInit;
         cnt_ff       <= 5'd0;
         whole_ff     <= 1'b0;
         close_ff     <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         section_ff   <= section_in;
         field_cnt_ff <= field_cnt_in;
         frame_pos_ff <= frame_pos_in;
         parity_ff    <= parity_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         whole_ff     <= whole_in;
         close_ff     <= close_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // sequencer: next step and the position emitted this cycle
   always_comb begin
      step_in      = step_ff;
      section_in   = section_ff;
      field_cnt_in = field_cnt_ff;
      frame_pos_in = frame_pos_ff;
      parity_in    = parity_ff;
      crc_in       = crc_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      whole_in     = whole_ff;
      close_in     = close_ff;
      fin_in       = fin_ff;
      emit_req     = 1'b0;
      sym          = 8'd0;
      feed         = 1'b0;
      sym_last     = 1'b0;

      unique case (step_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = 5'd0;
               if (req_mode == ModeStart) begin
                  // new descriptor: header starts with a frame of ones
                  step_in      = ST_ONES;
                  crc_in       = CrcInit;
                  frame_pos_in = 5'd0;
                  parity_in    = 1'b0;
                  field_cnt_in = 8'd0;
                  whole_in     = 1'b0;
                  section_in   = (first_len_ff != 8'd0) ? SEC_SEQ1 : after_first;
               end else begin
                  unique case (section_ff)
                     SEC_SEQ1, SEC_SEQ2: begin
                        step_in  = ST_FIELD;
                        shift_in = req_field_value;
                        whole_in = 1'b1;
                        fin_in   = 1'b0;
                        close_in = (cnt_next >= {1'b0, (section_ff == SEC_SEQ1) ?
                                                 first_len_ff : second_len_ff});
                        if (close_in) begin
                           field_cnt_in = 8'd0;
                           section_in   = (section_ff == SEC_SEQ1) ? after_first
                                                                   : SEC_SIZES;
                        end else begin
                           field_cnt_in = cnt_next[7:0];
                        end
                     end
                     SEC_SIZES, SEC_CODES: begin
                        step_in  = ST_FIELD;
                        shift_in = {1'b0, req_field_value[6:0]};
                        whole_in = 1'b0;
                        close_in = field_cnt_ff[0];
                        fin_in   = 1'b0;
                        if (cnt_next >= 9'(SegmentFields)) begin
                           field_cnt_in = 8'd0;
                           if (section_ff == SEC_SIZES) begin
                              section_in = SEC_CODES;
                           end else if (dil_total == 9'd0) begin
                              fin_in     = 1'b1;
                              section_in = SEC_IDLE;
                           end else begin
                              section_in = SEC_DIL;
                           end
                        end else begin
                           field_cnt_in = cnt_next[7:0];
                        end
                     end
                     SEC_DIL: begin
                        step_in  = ST_FIELD;
                        shift_in = {1'b0, req_field_value[6:0]};
                        whole_in = 1'b0;
                        close_in = field_cnt_ff[0];
                        if (cnt_next >= dil_total) begin
                           fin_in       = 1'b1;
                           section_in   = SEC_IDLE;
                           field_cnt_in = 8'd0;
                        end else begin
                           fin_in       = 1'b0;
                           field_cnt_in = cnt_next[7:0];
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         ST_ONES: begin
            emit_req = 1'b1;
            sym      = 8'd1;
            if (emit) begin
               if (cnt_ff == FrameLastPos) begin
                  step_in  = ST_HDR_DIL;
                  cnt_in   = 5'd0;
                  shift_in = dil_count_ff;
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end

         // serial data: framing zero first when on a frame boundary
         ST_HDR_DIL, ST_HDR_LEN1, ST_HDR_LEN2, ST_FIELD: begin
            emit_req = 1'b1;
            feed     = 1'b1;
            if (frame_pos_ff != 5'd0) begin
               sym = whole_ff ? shift_ff : {7'd0, shift_ff[0]};
               if (emit) begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  cnt_in   = cnt_ff + 5'd1;
                  if (whole_ff || cnt_ff == 5'd7) begin
                     cnt_in = 5'd0;
                     unique case (step_ff)
                        ST_HDR_DIL:  step_in = ST_HDR_CLOSE1;
                        ST_HDR_LEN1: begin
                           step_in  = ST_HDR_LEN2;
                           shift_in = second_hdr;
                        end
                        ST_HDR_LEN2: step_in = ST_HDR_CLOSE2;
                        default: begin
                           if (close_ff)    step_in = ST_FIELD_CLOSE;
                           else if (fin_ff) step_in = ST_FIN_CLOSE;
                           else             step_in = ST_IDLE;
                        end
                     endcase
                  end
               end
            end
         end

         // zeros up to and including the next framing position
         ST_HDR_CLOSE1, ST_HDR_CLOSE2, ST_FIELD_CLOSE, ST_FIN_CLOSE: begin
            if (step_ff == ST_FIN_CLOSE && frame_pos_ff == 5'd1) begin
               // frame already closed: straight on to the crc
               step_in = ST_CRC;
               cnt_in  = 5'd0;
            end else begin
               emit_req = 1'b1;
               feed     = 1'b1;
               if (emit && frame_pos_ff == 5'd0) begin
                  cnt_in = 5'd0;
                  unique case (step_ff)
                     ST_HDR_CLOSE1: begin
                        step_in  = ST_HDR_LEN1;
                        shift_in = first_hdr;
                     end
                     ST_HDR_CLOSE2:  step_in = ST_IDLE;
                     ST_FIELD_CLOSE: step_in = fin_ff ? ST_FIN_CLOSE : ST_IDLE;
                     default:        step_in = ST_CRC;
                  endcase
               end
            end
         end

         // crc stages, stage 0 first, by rotating the register
         ST_CRC: begin
            emit_req = 1'b1;
            sym      = {7'd0, crc_ff[0]};
            if (emit) begin
               crc_in = {crc_ff[0], crc_ff[15:1]};
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) begin
                  step_in = ST_TAIL;
               end
            end
         end

         // trailing framing zero, plus one more for an even total
         ST_TAIL: begin
            emit_req = 1'b1;
            sym_last = parity_ff;
            if (emit && parity_ff) begin
               step_in = ST_IDLE;
            end
         end

         default: step_in = ST_IDLE;
      endcase

      // effect of one emitted position on cursor, parity and crc
      if (emit) begin
         frame_pos_in = (frame_pos_ff == FrameLastPos) ? 5'd0 : frame_pos_ff + 5'd1;
         parity_in    = !parity_ff;
         if (feed && frame_pos_ff != 5'd0) begin
            crc_in = {1'b0, crc_ff[15:1]} ^ (crc_fb ? CrcPoly : 16'd0);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = sym;
         rsp_last_in   = sym_last;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
